// ----- hw/rtl/nseg_pkg.sv -----
package nseg_pkg;

    localparam int unsigned PULSE_LENGTH_DEF = 192;
    localparam int unsigned BANG_REPEATS_DEF = 5;

    localparam logic [8:0] THUD_SAMPLES = 9'((16'h0150 - 16'h0080) / 2);
    localparam logic [8:0] BANG_PITCHES = 9'((16'h0150 - 16'h0050) / 2);

    localparam logic [15:0] ATTACK_STEP  = 16'h0080;
    localparam logic [15:0] WHOOSH_DECAY = 16'h00A0;
    localparam logic [15:0] KLINK_DECAY  = 16'h0060;
    localparam logic [15:0] LEVEL_FULL   = 16'hFFFF;
    localparam logic [7:0]  SAMPLE_MASK  = 8'hFC;
    localparam logic [7:0]  KLINK_SET    = 8'h80;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    localparam logic [2:0] EFF_THUD   = 3'd0;
    localparam logic [2:0] EFF_WHOOSH = 3'd1;
    localparam logic [2:0] EFF_KLINK  = 3'd2;
    localparam logic [2:0] EFF_BANG   = 3'd3;
    localparam logic [2:0] EFF_PULSE  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX,
        S_SCALE,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/nseg_mul.sv -----
module nseg_mul
    import nseg_pkg::*;
(
    input  logic        i_clk,
    input  logic [7:0]  i_a,
    input  logic [7:0]  i_b,
    output logic [15:0] o_prod
);

    logic [15:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 16'(i_a) * 16'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/noise_sound_effect_generator.sv -----
// Noise sound effect generator.
// Input channel (i_valid/o_ready) takes one request: a tick, an effect start
// or a noise word load. Every request gives exactly one result on the output
// channel (o_valid/i_ready): a sample with its valid and done flags, or all
// zeros for starts, loads, unused modes and ticks while idle.
// A request is taken only while the sequencer is idle. A tick that makes an
// enveloped sample passes S_MIX, S_SCALE and S_OUT on its way to the output
// register: the shared 8x8 multiplier runs once for the envelope mix and once
// for the volume scale. A plain sample passes S_SCALE and S_OUT; a request
// without a sample only S_OUT. No new request is taken before the last leaves S_OUT.
// The output register frees the input side: the next request is taken while a
// result still waits. When the receiver stalls with a result held, the next
// result waits in the sequencer and no further request is taken.
// Reset clears the noise word, the effect state and the output register, and
// leaves the block idle with no effect running.
module noise_sound_effect_generator
    import nseg_pkg::*;
#(
    parameter int unsigned PULSE_LENGTH = PULSE_LENGTH_DEF,
    parameter int unsigned BANG_REPEATS = BANG_REPEATS_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_effect,
    input  logic [7:0]  i_volume,
    input  logic [7:0]  i_pulse_count,
    input  logic [15:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_sample,
    output logic        o_sample_valid,
    output logic        o_effect_done
);

    localparam logic [7:0] PULSE_LEN = 8'(PULSE_LENGTH);
    localparam logic [7:0] BANG_REP  = 8'(BANG_REPEATS);

    t_state      r_state, n_state;
    logic [15:0] r_noise, n_noise;
    logic [15:0] r_level, n_level;
    logic [2:0]  r_effect, n_effect;
    logic        r_running, n_running;
    logic        r_phase, n_phase;
    logic [8:0]  r_pitch, n_pitch;
    logic [7:0]  r_repeat, n_repeat;
    logic [7:0]  r_pulses, n_pulses;
    logic [7:0]  r_volume, n_volume;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_n, n_n;
    logic        r_mixed, n_mixed;
    logic        r_pvalid, n_pvalid;
    logic        r_pdone, n_pdone;
    logic        r_out_valid;
    logic [7:0]  r_out_sample;
    logic        r_out_svalid;
    logic        r_out_done;

    logic        accept;
    logic        out_load;
    logic [15:0] noise_mul;
    logic [15:0] noise_adv;
    logic [7:0]  nh;
    logic [16:0] attack_sum;
    logic [15:0] decay_amt;
    logic [16:0] decay_diff;
    logic        decay_ok;
    logic [8:0]  pitch_inc;
    logic [7:0]  repeat_inc;
    logic [7:0]  mul_a;
    logic [7:0]  mul_b;
    logic [15:0] prod;

    nseg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign accept    = i_valid && o_ready;
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_ready);
    assign o_ready   = (r_state == S_IDLE);

    assign noise_mul  = r_noise + {r_noise[13:0], 2'b00};
    assign noise_adv  = {noise_mul[15:8], noise_mul[7:0] + 8'd1};
    assign nh         = noise_adv[15:8];
    assign attack_sum = {1'b0, r_level} + {1'b0, ATTACK_STEP};
    assign decay_amt  = (r_effect == EFF_KLINK) ? KLINK_DECAY : WHOOSH_DECAY;
    assign decay_diff = {1'b0, r_level} - {1'b0, decay_amt};
    assign decay_ok   = !decay_diff[16] && (decay_diff[15:0] != 16'd0);
    assign pitch_inc  = r_pitch + 9'd1;
    assign repeat_inc = r_repeat + 8'd1;

    always_comb begin
        mul_a = r_x;
        mul_b = r_volume;
        if (r_state == S_MIX) begin
            mul_b = r_n;
        end else if (r_state == S_SCALE && r_mixed) begin
            mul_a = prod[15:8];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_noise   = r_noise;
        n_level   = r_level;
        n_effect  = r_effect;
        n_running = r_running;
        n_phase   = r_phase;
        n_pitch   = r_pitch;
        n_repeat  = r_repeat;
        n_pulses  = r_pulses;
        n_volume  = r_volume;
        n_x       = r_x;
        n_n       = r_n;
        n_mixed   = r_mixed;
        n_pvalid  = r_pvalid;
        n_pdone   = r_pdone;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pvalid = 1'b0;
                    n_pdone  = 1'b0;
                    n_mixed  = 1'b0;
                    n_x      = nh;
                    n_n      = nh;
                    n_state  = S_OUT;
                    if (i_mode == MODE_START) begin
                        n_running = 1'b0;
                        n_phase   = 1'b0;
                        n_pitch   = '0;
                        n_repeat  = '0;
                        n_volume  = i_volume;
                        n_pulses  = i_pulse_count;
                        if (i_effect <= EFF_PULSE &&
                            !(i_effect == EFF_PULSE && i_pulse_count == 8'd0)) begin
                            n_effect  = i_effect;
                            n_running = 1'b1;
                            n_level   = (i_effect == EFF_KLINK) ? LEVEL_FULL : 16'd0;
                        end
                    end else if (i_mode == MODE_LOAD) begin
                        n_noise = i_seed_value;
                    end else if (i_mode == MODE_TICK && r_running) begin
                        n_noise = noise_adv;
                        case (r_effect)
                            EFF_THUD: begin
                                n_pvalid = 1'b1;
                                n_pitch  = pitch_inc;
                                n_pdone  = (pitch_inc >= THUD_SAMPLES);
                            end
                            EFF_WHOOSH: begin
                                if (!r_phase) begin
                                    if (attack_sum[16]) begin
                                        n_level = LEVEL_FULL;
                                        n_phase = 1'b1;
                                    end else begin
                                        n_level  = attack_sum[15:0];
                                        n_pvalid = 1'b1;
                                        n_mixed  = 1'b1;
                                        n_x      = attack_sum[15:8];
                                    end
                                end else begin
                                    n_level = decay_diff[15:0];
                                    if (decay_ok) begin
                                        n_pvalid = 1'b1;
                                        n_mixed  = 1'b1;
                                        n_x      = decay_diff[15:8];
                                    end else begin
                                        n_pdone = 1'b1;
                                    end
                                end
                            end
                            EFF_KLINK: begin
                                n_n     = r_phase ? (nh | KLINK_SET) : {1'b0, nh[7:1]};
                                n_phase = !r_phase;
                                n_level = decay_diff[15:0];
                                if (decay_ok) begin
                                    n_pvalid = 1'b1;
                                    n_mixed  = 1'b1;
                                    n_x      = decay_diff[15:8];
                                end else begin
                                    n_pdone = 1'b1;
                                end
                            end
                            EFF_BANG: begin
                                n_pvalid = 1'b1;
                                n_repeat = repeat_inc;
                                if (repeat_inc >= BANG_REP) begin
                                    n_repeat = '0;
                                    n_pitch  = pitch_inc;
                                    n_pdone  = (pitch_inc >= BANG_PITCHES);
                                end
                            end
                            default: begin
                                n_pvalid = 1'b1;
                                n_repeat = repeat_inc;
                                if (repeat_inc >= PULSE_LEN) begin
                                    n_repeat = '0;
                                    n_pulses = r_pulses - 8'd1;
                                    n_pdone  = (r_pulses == 8'd1);
                                end
                            end
                        endcase
                        if (n_pdone) begin
                            n_running = 1'b0;
                        end
                        if (n_pvalid) begin
                            n_state = n_mixed ? S_MIX : S_SCALE;
                        end
                    end
                end
            end
            S_MIX: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                if (r_mixed) begin
                    n_x = prod[15:8];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_noise   <= '0;
            r_level   <= '0;
            r_effect  <= '0;
            r_running <= 1'b0;
            r_phase   <= 1'b0;
            r_pitch   <= '0;
            r_repeat  <= '0;
            r_pulses  <= '0;
            r_volume  <= '0;
            r_pvalid  <= 1'b0;
            r_pdone   <= 1'b0;
            r_mixed   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_noise   <= n_noise;
            r_level   <= n_level;
            r_effect  <= n_effect;
            r_running <= n_running;
            r_phase   <= n_phase;
            r_pitch   <= n_pitch;
            r_repeat  <= n_repeat;
            r_pulses  <= n_pulses;
            r_volume  <= n_volume;
            r_pvalid  <= n_pvalid;
            r_pdone   <= n_pdone;
            r_mixed   <= n_mixed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_n <= n_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_out_sample <= '0;
            r_out_svalid <= 1'b0;
            r_out_done   <= 1'b0;
        end else if (out_load) begin
            r_out_valid  <= 1'b1;
            r_out_sample <= r_pvalid ? (prod[15:8] & SAMPLE_MASK) : 8'd0;
            r_out_svalid <= r_pvalid;
            r_out_done   <= r_pdone;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_sample_valid = r_out_svalid;
    assign o_effect_done  = r_out_done;

`ifndef ASSERT_OFF
    a_sample_low_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample[1:0] == 2'b00))
        else $error("sample low bits not zero");

    a_no_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sample_valid) |-> (o_sample == 8'd0))
        else $error("sample nonzero without sample valid");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("request taken while previous one in progress");

    a_pulses_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running && r_effect == EFF_PULSE) |-> (r_pulses != 8'd0))
        else $error("pulse effect running with no pulses left");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && accept && n_pdone) |=> !r_running)
        else $error("effect still running after done");
`endif

endmodule

// ----- tb/tb.sv -----
module tb;
    import nseg_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_COUNT = 1900;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  effect;
        logic [7:0]  volume;
        logic [7:0]  pulses;
        logic [15:0] seed;
        bit          drain;
    } t_sound_req;

    typedef struct packed {
        logic [7:0] sample;
        logic       sample_valid;
        logic       done;
    } t_sound_out;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [2:0]  i_effect = '0;
    logic [7:0]  i_volume = '0;
    logic [7:0]  i_pulse_count = '0;
    logic [15:0] i_seed_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_sample;
    logic        o_sample_valid;
    logic        o_effect_done;

    noise_sound_effect_generator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_effect       (i_effect),
        .i_volume       (i_volume),
        .i_pulse_count  (i_pulse_count),
        .i_seed_value   (i_seed_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample),
        .o_sample_valid (o_sample_valid),
        .o_effect_done  (o_effect_done)
    );

    t_sound_req pending_requests[$];
    t_sound_out expected_samples[$];
    t_sound_req driven_req;
    int n_total;
    int n_accepted;
    int n_results;
    int n_errors;
    int cycle_cnt;

    logic [15:0] noise_reg;
    logic [15:0] env_level;
    logic [2:0]  cur_effect;
    logic        fx_running;
    logic        phase_flag;
    logic [8:0]  pitch_cnt;
    logic [7:0]  rep_cnt;
    logic [7:0]  pulses_rem;
    logic [7:0]  vol_held;

    function automatic logic [7:0] dac_scale(logic [7:0] x);
        logic [15:0] p;
        p = x * vol_held;
        return p[15:8] & SAMPLE_MASK;
    endfunction

    function automatic logic [7:0] env_mix(logic [7:0] n);
        logic [15:0] m;
        m = env_level[15:8] * n;
        return dac_scale(m[15:8]);
    endfunction

    // Returns zero when the decay phase ends on a borrow or on reaching zero.
    function automatic bit env_decay(logic [15:0] amount);
        bit borrow;
        borrow = env_level < amount;
        env_level = env_level - amount;
        return !(borrow || env_level == 16'h0);
    endfunction

    function automatic t_sound_out sound_model_step(t_sound_req r);
        t_sound_out o;
        logic [15:0] v;
        logic [7:0]  nh;
        logic [7:0]  n;
        logic [16:0] sum;
        o = '0;
        case (r.mode)
            MODE_START: begin
                fx_running = 1'b0;
                phase_flag = 1'b0;
                pitch_cnt = '0;
                rep_cnt = '0;
                vol_held = r.volume;
                pulses_rem = r.pulses;
                if (r.effect <= EFF_PULSE && !(r.effect == EFF_PULSE && r.pulses == 8'h0)) begin
                    cur_effect = r.effect;
                    fx_running = 1'b1;
                    env_level = (r.effect == EFF_KLINK) ? LEVEL_FULL : 16'h0;
                end
            end
            MODE_LOAD: noise_reg = r.seed;
            MODE_TICK: begin
                if (fx_running) begin
                    v = noise_reg * 16'd5;
                    noise_reg = {v[15:8], v[7:0] + 8'd1};
                    nh = noise_reg[15:8];
                    case (cur_effect)
                        EFF_THUD: begin
                            o.sample = dac_scale(nh);
                            o.sample_valid = 1'b1;
                            pitch_cnt = pitch_cnt + 9'd1;
                            if (pitch_cnt >= THUD_SAMPLES) o.done = 1'b1;
                        end
                        EFF_WHOOSH: begin
                            if (!phase_flag) begin
                                sum = {1'b0, env_level} + {1'b0, ATTACK_STEP};
                                env_level = sum[15:0];
                                if (sum[16]) begin
                                    env_level = LEVEL_FULL;
                                    phase_flag = 1'b1;
                                end else begin
                                    o.sample = env_mix(nh);
                                    o.sample_valid = 1'b1;
                                end
                            end else if (env_decay(WHOOSH_DECAY)) begin
                                o.sample = env_mix(nh);
                                o.sample_valid = 1'b1;
                            end else begin
                                o.done = 1'b1;
                            end
                        end
                        EFF_KLINK: begin
                            n = phase_flag ? (nh | KLINK_SET) : (nh >> 1);
                            phase_flag = ~phase_flag;
                            if (env_decay(KLINK_DECAY)) begin
                                o.sample = env_mix(n);
                                o.sample_valid = 1'b1;
                            end else begin
                                o.done = 1'b1;
                            end
                        end
                        EFF_BANG: begin
                            o.sample = dac_scale(nh);
                            o.sample_valid = 1'b1;
                            rep_cnt = rep_cnt + 8'd1;
                            if (rep_cnt >= BANG_REPEATS_DEF) begin
                                rep_cnt = '0;
                                pitch_cnt = pitch_cnt + 9'd1;
                                if (pitch_cnt >= BANG_PITCHES) o.done = 1'b1;
                            end
                        end
                        default: begin
                            o.sample = dac_scale(nh);
                            o.sample_valid = 1'b1;
                            rep_cnt = rep_cnt + 8'd1;
                            if (rep_cnt >= PULSE_LENGTH_DEF) begin
                                rep_cnt = '0;
                                pulses_rem = pulses_rem - 8'd1;
                                if (pulses_rem == 8'h0) o.done = 1'b1;
                            end
                        end
                    endcase
                    if (o.done) fx_running = 1'b0;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic push_req(logic [1:0] m, logic [2:0] e, logic [7:0] v, logic [7:0] p,
                            logic [15:0] s, bit d);
        t_sound_req r;
        r.mode = m;
        r.effect = e;
        r.volume = v;
        r.pulses = p;
        r.seed = s;
        r.drain = d;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // Ticks carry random junk in the fields that the block ignores.
    task automatic push_ticks(int n);
        for (int i = 0; i < n; i++) begin
            push_req(MODE_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
        end
    endtask

    task automatic push_start(logic [2:0] e, logic [7:0] v, logic [7:0] p, bit d);
        push_req(MODE_START, e, v, p, 16'($urandom), d);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int n;
        logic [2:0] eff;
        logic [7:0] pc;
        bit full;

        noise_reg = '0;
        env_level = '0;
        cur_effect = '0;
        fx_running = 1'b0;
        phase_flag = 1'b0;
        pitch_cnt = '0;
        rep_cnt = '0;
        pulses_rem = '0;
        vol_held = '0;
        n_accepted = 0;
        n_results = 0;
        n_errors = 0;

        push_ticks(1);
        push_req(MODE_NONE, 3'd7, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        push_req(MODE_LOAD, 3'd0, 8'h00, 8'h00, 16'hFFFF, 1'b0);
        push_start(EFF_THUD, 8'hFF, 8'h00, 1'b0);
        push_ticks(2);
        push_req(MODE_LOAD, 3'd7, 8'hFF, 8'hFF, 16'h0000, 1'b0);
        push_ticks(1);
        push_start(EFF_WHOOSH, 8'h00, 8'hFF, 1'b0);
        push_ticks(2);
        push_start(EFF_KLINK, 8'hFF, 8'h00, 1'b0);
        push_ticks(3);
        push_start(EFF_BANG, 8'h80, 8'h55, 1'b0);
        push_ticks(2);
        push_start(EFF_PULSE, 8'hFF, 8'h00, 1'b0);
        push_ticks(1);
        push_start(EFF_PULSE, 8'hFF, 8'hFF, 1'b1);
        push_ticks(1);
        push_start(3'd5, 8'hAA, 8'h01, 1'b0);
        push_ticks(1);
        push_start(3'd7, 8'h55, 8'h01, 1'b0);
        push_ticks(1);

        // Full runs of the long effects, so that their endings are reached.
        push_start(EFF_WHOOSH, 8'($urandom), 8'($urandom), 1'b1);
        push_ticks(925);
        push_start(EFF_BANG, 8'($urandom), 8'($urandom), 1'b0);
        push_ticks(645);

        while (pending_requests.size() < ITEM_COUNT) begin
            if ($urandom_range(99) < 8) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    push_req(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                             16'($urandom), 1'b0);
                end
            end else begin
                eff = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(4));
                pc = 8'($urandom);
                if (eff == EFF_PULSE) begin
                    case ($urandom_range(9))
                        0: pc = 8'h00;
                        1: pc = 8'($urandom);
                        default: pc = 8'($urandom_range(1, 2));
                    endcase
                end
                push_start(eff, 8'($urandom), pc, $urandom_range(19) == 0);
                full = ($urandom_range(2) == 0)
                    && (eff == EFF_THUD || (eff == EFF_PULSE && pc == 8'h01));
                n = full ? ((eff == EFF_THUD) ? 106 : 194) : $urandom_range(1, 80);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(29) == 0) begin
                        push_req(MODE_LOAD, 3'($urandom), 8'($urandom), 8'($urandom),
                                 16'($urandom), 1'b0);
                    end else begin
                        push_ticks(1);
                    end
                end
            end
        end
        n_total = pending_requests.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_valid || expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    always @(posedge i_clk) begin : driver
        int send_idle;
        bit go;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (n_accepted * 3 < n_total) send_idle = 12;
            else if (n_accepted * 3 < n_total * 2) send_idle = 87;
            else send_idle = 0;
            if (i_valid && o_ready) begin
                expected_samples.insert(expected_samples.size(),
                                        sound_model_step(driven_req));
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                go = 1'b0;
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
                    go = !(pending_requests[0].drain && expected_samples.size() != 0);
                end
                if (go) begin
                    driven_req = pending_requests.pop_front();
                    i_mode <= driven_req.mode;
                    i_effect <= driven_req.effect;
                    i_volume <= driven_req.volume;
                    i_pulse_count <= driven_req.pulses;
                    i_seed_value <= driven_req.seed;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        int recv_idle;
        t_sound_out want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (n_results * 3 < n_total) recv_idle = 87;
            else if (n_results * 3 < n_total * 2) recv_idle = 12;
            else recv_idle = 0;
            if (o_valid && i_ready) begin
                n_results++;
                if (expected_samples.size() == 0) begin
                    $error("result with no request waiting: sample %0h", o_sample);
                    n_errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (o_sample !== want.sample) begin
                        $error("sample: expected %0h, got %0h", want.sample, o_sample);
                        n_errors++;
                    end
                    if (o_sample_valid !== want.sample_valid) begin
                        $error("sample_valid: expected %0b, got %0b",
                               want.sample_valid, o_sample_valid);
                        n_errors++;
                    end
                    if (o_effect_done !== want.done) begin
                        $error("effect_done: expected %0b, got %0b", want.done, o_effect_done);
                        n_errors++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial cycle_cnt = 0;

endmodule

// ----- noise_sound_effect_generator.f -----
hw/rtl/nseg_pkg.sv
hw/rtl/nseg_mul.sv
hw/rtl/noise_sound_effect_generator.sv
tb/tb.sv
